@@ design/potb_pkg.sv @@
// Package for the periodic / one-shot timer bank.
// Holds sizes, command and result codes, item and per-slot types.
// No dependencies.
package potb_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int COUNT_WIDTH = 16;

  localparam int TID_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SEL_W = (TID_W > 4) ? TID_W : 4;
  localparam int POS_W = $clog2(NUM_TIMERS + 1);

  typedef enum logic [3:0] {
    CMD_TICK       = 4'd0,
    CMD_CREATE     = 4'd1,
    CMD_DELETE     = 4'd2,
    CMD_START      = 4'd3,
    CMD_STOP       = 4'd4,
    CMD_RESTART    = 4'd5,
    CMD_PAUSE      = 4'd6,
    CMD_RESUME     = 4'd7,
    CMD_SET_RELOAD = 4'd8,
    CMD_SET_MODE   = 4'd9,
    CMD_QUERY      = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_ONESHOT = 2'd1
  } mode_e;

  typedef enum logic [1:0] {
    EV_STATUS    = 2'd0,
    EV_EXPIRED   = 2'd1,
    EV_TICK_DONE = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DELETED  = 2'd1,
    ST_BAD_MODE = 2'd2,
    ST_IN_USE   = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  timer_index;
    logic [15:0] reload_value;
    mode_e       mode_value;
  } in_item_t;

  typedef struct packed {
    event_e     event_kind;
    logic [3:0] timer_id;
    status_e    status;
    logic       is_running;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic oneshot;
    logic paused;
    logic running;
    logic alloc;
  } flags_t;

  // Operation travelling down the chain of slot cells.
  typedef struct packed {
    logic                   valid;
    cmd_e                   cmd;
    logic [3:0]             idx;
    logic [COUNT_WIDTH-1:0] reload;
    mode_e                  mode;
    status_e                status;
    logic                   running;
  } pkt_t;

endpackage

@@ design/periodic_oneshot_timer_bank_top.sv @@
// Top level of the periodic / one-shot timer bank: input register, chain of
// slot cells, step counter and result register.
// Depends on potb_pkg and potb_cell.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+------------
//  in      | into bank | in_valid_i / in_stall_o      | in_item_i
//  out     | from bank | out_valid_o / out_stall_i    | out_item_o
//
// Every tick or command runs once through the chain of NUM_TIMERS cells, one
// cell per cycle while the result register is free to take a result, then
// drops its closing result; no new item is taken while a pass is under way.
// A stalled result register freezes the whole chain, so results of a tick
// never overtake each other. Unknown commands are taken and dropped without a
// result. Reset clears every slot (all deleted) and empties the chain.
module periodic_oneshot_timer_bank_top import potb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_TIMERS);

  pkt_t                  head_q;
  pkt_t                  pkt_w [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0] fire_w;

  logic             busy_q, busy_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic accept, known, out_free, adv, at_end;

  assign accept   = in_valid_i && !busy_q;
  assign known    = in_item_i.cmd inside {[CMD_TICK:CMD_QUERY]};
  assign out_free = !out_valid_q || !out_stall_i;
  // chain only moves when a result it may produce has somewhere to go
  assign adv      = busy_q && out_free;
  assign at_end   = (pos_q == LAST_POS);

  // Build the packet. Default status covers a slot nobody answers for: OK for a
  // tick, bad mode for create / set mode with an unknown mode, otherwise deleted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (accept) begin
      head_q.valid   <= known;
      head_q.cmd     <= in_item_i.cmd;
      head_q.idx     <= in_item_i.timer_index;
      head_q.reload  <= COUNT_WIDTH'(in_item_i.reload_value);
      head_q.mode    <= in_item_i.mode_value;
      head_q.running <= 1'b0;
      if (in_item_i.cmd == CMD_TICK) begin
        head_q.status <= ST_OK;
      end else if (((in_item_i.cmd == CMD_CREATE) || (in_item_i.cmd == CMD_SET_MODE)) &&
                   (in_item_i.mode_value != MODE_FREE) &&
                   (in_item_i.mode_value != MODE_ONESHOT)) begin
        head_q.status <= ST_BAD_MODE;
      end else begin
        head_q.status <= ST_DELETED;
      end
    end else if (adv) begin
      head_q.valid <= 1'b0;
    end
  end

  assign pkt_w[0] = head_q;

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    potb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .cell_id_i (TID_W'(k)),
      .pkt_i     (pkt_w[k]),
      .pkt_o     (pkt_w[k+1]),
      .fire_o    (fire_w[k])
    );
  end

  // step counter and result register
  always_comb begin
    busy_d      = busy_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    if (accept && known) begin
      busy_d = 1'b1;
      pos_d  = '0;
    end

    if (adv) begin
      if (at_end) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
        if (pkt_w[NUM_TIMERS].cmd == CMD_TICK) begin
          out_item_d.event_kind = EV_TICK_DONE;
          out_item_d.timer_id   = '0;
          out_item_d.status     = ST_OK;
          out_item_d.is_running = 1'b0;
        end else begin
          out_item_d.event_kind = EV_STATUS;
          out_item_d.timer_id   = pkt_w[NUM_TIMERS].idx;
          out_item_d.status     = pkt_w[NUM_TIMERS].status;
          out_item_d.is_running = pkt_w[NUM_TIMERS].running;
        end
        out_item_d.last = 1'b1;
      end else begin
        pos_d = pos_q + POS_W'(1);
        if (fire_w != '0) begin
          out_valid_d           = 1'b1;
          out_item_d.event_kind = EV_EXPIRED;
          out_item_d.timer_id   = 4'(pos_q);
          out_item_d.status     = ST_OK;
          out_item_d.is_running = 1'b0;
          out_item_d.last       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // only the cell holding the operation can expire
  a_one_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(fire_w))
    else $error("more than one cell expired in one step");

  a_fire_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_w != '0) |-> (busy_q && !at_end))
    else $error("expiry outside a chain pass");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && at_end) |=> (!busy_q && out_valid_q && out_item_q.last))
    else $error("closing result missing at end of pass");

  a_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !pkt_w[NUM_TIMERS].valid)
    else $error("packet left in chain while idle");

endmodule

@@ design/potb_cell.sv @@
// One timer slot of the bank: count, reload and flags.
// Applies the operation passing through and hands it to the next cell.
// Depends on potb_pkg.
module potb_cell import potb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [TID_W-1:0] cell_id_i,
  input  pkt_t             pkt_i,
  output pkt_t             pkt_o,
  output logic             fire_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] reload_q, reload_d;
  flags_t                 flags_q, flags_d;
  pkt_t                   pkt_q, pkt_d;
  logic                   hit, tick, mode_ok, fire;

  always_comb begin
    count_d  = count_q;
    reload_d = reload_q;
    flags_d  = flags_q;
    pkt_d    = pkt_i;
    fire     = 1'b0;
    tick     = pkt_i.valid && (pkt_i.cmd == CMD_TICK);
    hit      = pkt_i.valid && (pkt_i.cmd != CMD_TICK) &&
               (SEL_W'(pkt_i.idx) == SEL_W'(cell_id_i));
    mode_ok  = (pkt_i.mode == MODE_FREE) || (pkt_i.mode == MODE_ONESHOT);

    if (tick) begin
      if (flags_q.alloc && flags_q.running && !flags_q.paused && (count_q != '0)) begin
        count_d = count_q - COUNT_WIDTH'(1);
        if (count_q == COUNT_WIDTH'(1)) begin
          fire = 1'b1;
          if (flags_q.oneshot) begin
            flags_d.running = 1'b0;
          end else begin
            count_d = reload_q;
          end
        end
      end
    end else if (hit) begin
      case (pkt_i.cmd)
        CMD_CREATE: begin
          // bad mode already carried in the packet status
          if (mode_ok) begin
            if (flags_q.alloc) begin
              pkt_d.status = ST_IN_USE;
            end else begin
              pkt_d.status    = ST_OK;
              count_d         = '0;
              reload_d        = pkt_i.reload;
              flags_d         = '0;
              flags_d.alloc   = 1'b1;
              flags_d.oneshot = (pkt_i.mode == MODE_ONESHOT);
            end
          end
        end
        CMD_SET_MODE: begin
          if (mode_ok) begin
            if (!flags_q.alloc) begin
              pkt_d.status = ST_DELETED;
            end else begin
              pkt_d.status    = ST_OK;
              flags_d.oneshot = (pkt_i.mode == MODE_ONESHOT);
            end
          end
        end
        default: begin
          if (!flags_q.alloc) begin
            pkt_d.status = ST_DELETED;
          end else begin
            pkt_d.status = ST_OK;
            case (pkt_i.cmd)
              CMD_DELETE:     flags_d = '0;
              CMD_START: begin
                count_d         = reload_q;
                flags_d.running = 1'b1;
              end
              CMD_STOP:       flags_d.running = 1'b0;
              CMD_RESTART: begin
                reload_d        = pkt_i.reload;
                count_d         = pkt_i.reload;
                flags_d.running = 1'b1;
              end
              CMD_PAUSE:      flags_d.paused = 1'b1;
              CMD_RESUME:     flags_d.paused = 1'b0;
              CMD_SET_RELOAD: reload_d = pkt_i.reload;
              CMD_QUERY:      pkt_d.running = flags_q.running;
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      reload_q <= '0;
      flags_q  <= '0;
      pkt_q    <= '0;
    end else if (adv_i) begin
      count_q  <= count_d;
      reload_q <= reload_d;
      flags_q  <= flags_d;
      pkt_q    <= pkt_d;
    end
  end

  assign pkt_o  = pkt_q;
  assign fire_o = fire;

endmodule
